// File: design/dmc_pkg.sv
// Shared types and constants for the direct-mapped cache tag checker.
package dmc_pkg;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned TagWidth   = 32;
  localparam int unsigned NumLines   = 16384;
  localparam int unsigned LineWidth  = $clog2(NumLines);
  localparam int unsigned CountWidth = 32;
  localparam int unsigned RegWidth   = 4;
  localparam int unsigned SplitWidth = 5;

  localparam logic [RegWidth-1:0] OffsetMax   = 4'd12;
  localparam logic [RegWidth-1:0] IndexMax    = 4'd14;
  localparam logic [RegWidth-1:0] OffsetReset = 4'd4;
  localparam logic [RegWidth-1:0] IndexReset  = 4'd8;

  // register decode on paddr[2]
  localparam logic RegOffset = 1'b0;
  localparam logic RegIndex  = 1'b1;

  typedef struct packed {
    logic [RegWidth-1:0] offset_bits;
    logic [RegWidth-1:0] index_bits;
  } cfg_t;

  typedef struct packed {
    logic                 clear;
    logic [LineWidth-1:0] clear_addr;
    logic                 capture;
    logic                 resolve;
  } cmd_t;

endpackage

// File: design/dmc_regs.sv
// Configuration registers behind the APB-style port.
module dmc_regs import dmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [RegWidth-1:0] offset_q, offset_d;
  logic [RegWidth-1:0] index_q, index_d;
  logic                wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    offset_d = offset_q;
    index_d  = index_q;
    if (wr_en) begin
      case (paddr[2])
        RegOffset: offset_d = pwdata[RegWidth-1:0];
        RegIndex:  index_d  = pwdata[RegWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
      index_q  <= IndexReset;
    end else begin
      offset_q <= offset_d;
      index_q  <= index_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegOffset: prdata = {{(32-RegWidth){1'b0}}, offset_q};
      RegIndex:  prdata = {{(32-RegWidth){1'b0}}, index_q};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.offset_bits = offset_q;
  assign cfg_o.index_bits  = index_q;

endmodule

// File: design/dmc_ctrl.sv
// Controller: clearing pass after reset, then lookup sequencing per item.
module dmc_ctrl import dmc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_e;

  state_e               state_q, state_d;
  logic [LineWidth-1:0] clr_q, clr_d;
  logic                 done_q, done_d;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    done_d  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LineWidth'(NumLines - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  assign cmd_o.clear      = (state_q == S_CLEAR);
  assign cmd_o.clear_addr = clr_q;
  assign cmd_o.capture    = (state_q == S_IDLE) && start;
  assign cmd_o.resolve    = (state_q == S_LOOKUP);

endmodule

// File: design/dmc_datapath.sv
// Datapath: address split, tag RAM with valid bit, compare and counters.
module dmc_datapath import dmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  cmd_t                  cmd_i,
  input  logic [AddrWidth-1:0]  address_i,
  output logic                  hit_o,
  output logic [CountWidth-1:0] access_count_o,
  output logic [CountWidth-1:0] miss_count_o
);

  // word layout: {valid, tag}
  logic [TagWidth:0] mem [NumLines];
  logic [TagWidth:0] rd_q;

  logic [RegWidth-1:0]   ob, ib;
  logic [SplitWidth-1:0] split;
  logic [AddrWidth-1:0]  shifted;
  logic [LineWidth-1:0]  idx_mask, line_d, line_q;
  logic [TagWidth-1:0]   tag_d, tag_q;
  logic                  hit;

  logic                  we;
  logic [LineWidth-1:0]  waddr;
  logic [TagWidth:0]     wdata;

  logic [CountWidth-1:0] acc_q, acc_d, miss_q, miss_d;
  logic                  hit_q;

  assign ob       = (cfg_i.offset_bits > OffsetMax) ? OffsetMax : cfg_i.offset_bits;
  assign ib       = (cfg_i.index_bits > IndexMax) ? IndexMax : cfg_i.index_bits;
  assign split    = {1'b0, ob} + {1'b0, ib};
  assign shifted  = address_i >> ob;
  assign idx_mask = ~({LineWidth{1'b1}} << ib);
  assign line_d   = shifted[LineWidth-1:0] & idx_mask;
  assign tag_d    = TagWidth'(address_i >> split);

  assign hit = rd_q[TagWidth] && (rd_q[TagWidth-1:0] == tag_q);

  assign we    = cmd_i.clear || (cmd_i.resolve && !hit);
  assign waddr = cmd_i.clear ? cmd_i.clear_addr : line_q;
  assign wdata = cmd_i.clear ? '0 : {1'b1, tag_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.capture) begin
      rd_q <= mem[line_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      line_q <= line_d;
      tag_q  <= tag_d;
    end
    if (cmd_i.resolve) begin
      hit_q <= hit;
    end
  end

  always_comb begin
    acc_d  = acc_q;
    miss_d = miss_q;
    if (cmd_i.resolve) begin
      if (acc_q != '1) acc_d = acc_q + 1'b1;
      if (!hit && miss_q != '1) miss_d = miss_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      miss_q <= '0;
    end else begin
      acc_q  <= acc_d;
      miss_q <= miss_d;
    end
  end

  assign hit_o          = hit_q;
  assign access_count_o = acc_q;
  assign miss_count_o   = miss_q;

endmodule

// File: design/direct_mapped_cache_tag_check.sv
// Direct-mapped cache tag check: hit/miss per address with saturating counts.
// Flow: after start is taken, the tag RAM is read, then the compare and write-back
// are done and done_o pulses; a new start is not taken while busy is high.
// Reset: registers return to offset_bits=4, index_bits=8, counts to zero; a
// clearing pass over all 16384 lines wipes the valid bits while busy stays high.
// done_o is a one-cycle strobe and hit_o holds until the next item; the receiver cannot stall.
module direct_mapped_cache_tag_check import dmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [AddrWidth-1:0]  address_i,
  output logic                  done_o,
  output logic                  hit_o,
  output logic [CountWidth-1:0] access_count_o,
  output logic [CountWidth-1:0] miss_count_o
);

  cfg_t cfg;
  cmd_t cmd;

  dmc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  dmc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .address_i      (address_i),
    .hit_o          (hit_o),
    .access_count_o (access_count_o),
    .miss_count_o   (miss_count_o)
  );

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted item produced no result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (miss_count_o != '0))
    else $error("miss not counted");

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (access_count_o >= miss_count_o))
    else $error("more misses than accesses");

endmodule
